>>> design/bfpu_pkg.sv
// Package for the bit-field pack/unpack buffer.
// Holds request codes, field widths and the segment-unit control type.
// No dependencies.
package bfpu_pkg;

  localparam int FIELD_BITS = 32;
  localparam int COUNT_BITS = 6;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_REWIND = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef logic [1:0]            req_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Control handed to the shared segment unit for one word of a field.
  typedef struct packed {
    logic   is_write;
    count_t rem;
  } seg_ctl_t;

endpackage

>>> design/bfpu_if.sv
// Valid/ready channel interfaces for the bit-field pack/unpack buffer.
// Depends on bfpu_pkg.
interface bfpu_in_if;
  import bfpu_pkg::*;
  logic   valid;
  logic   ready;
  req_t   req_type;
  logic   is_signed;
  field_t value;
  count_t bit_count;

  modport source (output valid, input ready, output req_type, output is_signed,
                  output value, output bit_count);
  modport sink (input valid, output ready, input req_type, input is_signed,
                input value, input bit_count);
endinterface

interface bfpu_out_if;
  import bfpu_pkg::*;
  logic   valid;
  logic   ready;
  field_t read_value;
  logic   overflow;

  modport source (output valid, input ready, output read_value, output overflow);
  modport sink (input valid, output ready, input read_value, input overflow);
endinterface

>>> design/bfpu_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bfpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> design/bfpu_seg_unit.sv
// Shared segment unit: extracts or merges the part of a field that falls in one store word.
// Depends on bfpu_pkg.
module bfpu_seg_unit #(
  parameter int WORD_BITS = 32
) (
  input  bfpu_pkg::seg_ctl_t                ctl,
  input  logic [$clog2(WORD_BITS)-1:0]      bit_pos,
  input  logic [WORD_BITS-1:0]              word_in,
  input  bfpu_pkg::field_t                  value,
  input  bfpu_pkg::field_t                  acc_in,
  output bfpu_pkg::count_t                  take,
  output logic [WORD_BITS-1:0]              word_out,
  output bfpu_pkg::field_t                  acc_out
);
  import bfpu_pkg::*;

  localparam int XW = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;

  logic [7:0]  room;
  logic [7:0]  rem8;
  logic [7:0]  take8;
  logic [7:0]  sh;
  logic [7:0]  rem_after;
  logic [XW:0] mask_full;
  logic [XW-1:0] mask_x;
  logic [XW-1:0] word_x;
  logic [XW-1:0] field_x;
  logic [XW-1:0] seg_x;
  logic [XW-1:0] merged;

  always_comb begin
    // Bits left in this word from the cursor, and how many of them the field uses.
    room      = 8'(WORD_BITS) - 8'(bit_pos);
    rem8      = 8'(ctl.rem);
    take8     = (rem8 < room) ? rem8 : room;
    sh        = room - take8;
    rem_after = rem8 - take8;
    mask_full = ((XW + 1)'(1) << take8) - (XW + 1)'(1);
    mask_x    = mask_full[XW-1:0];
    word_x    = XW'(word_in);
    field_x   = (word_x >> sh) & mask_x;
    seg_x     = XW'(value >> rem_after) & mask_x;
    merged    = word_x | (seg_x << sh);
    take      = 6'(take8);
    if (ctl.is_write) begin
      word_out = merged[WORD_BITS-1:0];
      acc_out  = acc_in;
    end else begin
      word_out = word_in;
      acc_out  = (acc_in << take8) | field_x[FIELD_BITS-1:0];
    end
  end

endmodule

>>> design/bit_field_pack_unpack_buffer_core.sv
// Top level of the MSB-first bit-field pack/unpack buffer.
// Depends on bfpu_pkg, bfpu_if, bfpu_ram and bfpu_seg_unit.
//
//   Channel   Direction  Payload
//   in_chan   sink       req_type, is_signed, value, bit_count
//   out_chan  source     read_value, overflow
//
// A field read or write passes from the transfer through a read state (ST_RD) and a merge
// state (ST_MRG) for each store word the field touches, one read and one merge per word on
// the single RAM port, then ST_OUT. Rewind goes straight to ST_OUT; clear first runs ST_CLR.
// After reset the block zeroes the store in a clearing pass over all STORE_WORDS words and
// takes no input until it finishes. A stalled result waits in the output register
// while the next item is already taken and worked on.
module bit_field_pack_unpack_buffer_core #(
  parameter int WORD_BITS   = 32,
  parameter int STORE_WORDS = 256
) (
  input logic       clk,
  input logic       rst_n,
  bfpu_in_if.sink   in_chan,
  bfpu_out_if.source out_chan
);
  import bfpu_pkg::*;

  localparam int BW   = $clog2(WORD_BITS);
  localparam int CW   = $clog2(STORE_WORDS + 1);
  localparam int AW   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CAP  = STORE_WORDS * WORD_BITS;
  localparam int LW   = $clog2(CAP + 1);
  localparam int CMPW = (LW > COUNT_BITS) ? LW : COUNT_BITS;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MRG  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] word_r, word_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [LW-1:0] left_r, left_nxt;
  count_t        rem_r, rem_nxt;
  field_t        acc_r, acc_nxt;
  req_t          req_r, req_nxt;
  logic          sgn_r, sgn_nxt;
  field_t        val_r, val_nxt;
  count_t        n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clr_item_r, clr_item_nxt;
  logic          out_valid_r, out_valid_nxt;
  field_t        out_rd_r, out_rd_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic                 in_fire;
  count_t               n_sat;
  logic                 ram_en, ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  seg_ctl_t             seg_ctl;
  count_t               seg_take;
  logic [WORD_BITS-1:0] seg_word;
  field_t               seg_acc;
  logic [7:0]           bit_sum;
  field_t               rd_final;

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign in_fire             = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_value = out_rd_r;
  assign out_chan.overflow   = out_ovf_r;

  // Counts above the field width act as a full-width field.
  assign n_sat = (in_chan.bit_count > count_t'(FIELD_BITS)) ? count_t'(FIELD_BITS)
                                                             : in_chan.bit_count;

  bfpu_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign seg_ctl.is_write = (req_r == REQ_WRITE);
  assign seg_ctl.rem      = rem_r;

  bfpu_seg_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_seg (
    .ctl     (seg_ctl),
    .bit_pos (bit_r),
    .word_in (ram_rdata),
    .value   (val_r),
    .acc_in  (acc_r),
    .take    (seg_take),
    .word_out(seg_word),
    .acc_out (seg_acc)
  );

  assign bit_sum = 8'(bit_r) + 8'(seg_take);

  // A signed read fills the bits above the field with its top bit.
  always_comb begin
    rd_final = '0;
    if (req_r == REQ_READ && !ovf_r && n_r != '0) begin
      rd_final = acc_r;
      if (sgn_r && n_r < count_t'(FIELD_BITS) && acc_r[5'(n_r - 6'd1)]) begin
        rd_final = acc_r | ({FIELD_BITS{1'b1}} << n_r);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    left_nxt      = left_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    req_nxt       = req_r;
    sgn_nxt       = sgn_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    clr_addr_nxt  = clr_addr_r;
    clr_item_nxt  = clr_item_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_rd_nxt    = out_rd_r;
    out_ovf_nxt   = out_ovf_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = word_r[AW-1:0];
    ram_wdata     = seg_word;

    case (state_r)
      ST_CLR: begin
        // Zero one store word per cycle.
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(STORE_WORDS - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_item_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt = in_chan.req_type;
          sgn_nxt = in_chan.is_signed;
          val_nxt = in_chan.value;
          n_nxt   = n_sat;
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          rem_nxt = n_sat;
          if (in_chan.req_type == REQ_REWIND || in_chan.req_type == REQ_CLEAR) begin
            word_nxt  = '0;
            bit_nxt   = '0;
            left_nxt  = LW'(CAP);
            if (in_chan.req_type == REQ_CLEAR) begin
              clr_item_nxt = 1'b1;
              clr_addr_nxt = '0;
              state_nxt    = ST_CLR;
            end else begin
              state_nxt = ST_OUT;
            end
          end else if (n_sat == '0) begin
            state_nxt = ST_OUT;
          end else if (CMPW'(left_r) < CMPW'(n_sat)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            left_nxt  = left_r - LW'(n_sat);
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_en    = 1'b1;
        state_nxt = ST_MRG;
      end
      ST_MRG: begin
        // The word read last cycle passes through the shared unit once.
        if (req_r == REQ_WRITE) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
        end
        acc_nxt = seg_acc;
        rem_nxt = rem_r - seg_take;
        if (bit_sum == 8'(WORD_BITS)) begin
          bit_nxt  = '0;
          word_nxt = word_r + CW'(1);
        end else begin
          bit_nxt = BW'(bit_sum);
        end
        state_nxt = (rem_r == seg_take) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_final;
          out_ovf_nxt   = ovf_r;
          clr_item_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      word_r      <= '0;
      bit_r       <= '0;
      left_r      <= LW'(CAP);
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      bit_r       <= bit_nxt;
      left_r      <= left_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    acc_r     <= acc_nxt;
    req_r     <= req_nxt;
    sgn_r     <= sgn_nxt;
    val_r     <= val_nxt;
    n_r       <= n_nxt;
    ovf_r     <= ovf_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // An ignored access never returns field data.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.overflow |-> out_chan.read_value == '0)
    else $error("overflow result carries nonzero read_value");

  // The free-space count can never exceed the store's capacity.
  a_left_cap: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= LW'(CAP))
    else $error("free-space count above capacity");

  // The merge cycle only runs while part of the field remains.
  a_mrg_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MRG |-> rem_r != '0)
    else $error("merge cycle with no bits remaining");

  // Rewind and clear leave the cursor at the start of the store.
  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_chan.req_type == REQ_REWIND || in_chan.req_type == REQ_CLEAR)
    |=> word_r == '0 && bit_r == '0)
    else $error("cursor not rewound");

endmodule
